// ----- rtl/qes_pkg.sv -----
// ----------------------------------------------------------------------------
// qes_pkg
// Shared constants and types of the quadratic equation solver.
// ----------------------------------------------------------------------------
package qes_pkg;

  // Default coefficient format: signed Q16.16.
  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Zero tolerance register.
  localparam int                   TOL_WIDTH = 8;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd1;

  // Root count codes.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  // Control flags that travel down the pipeline with each request.
  typedef struct packed {
    logic [1:0] count;     // root count code
    logic       lin;       // linear case: first quotient is -c/b
    logic       dsign;     // sign of the divisor
    logic       nneg_lin;  // sign of the linear numerator -c
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

endpackage

// ----- rtl/qes_if.sv -----
// ----------------------------------------------------------------------------
// qes_if
// Valid/ready channels of the quadratic equation solver.
// ----------------------------------------------------------------------------

// Coefficient request channel.
interface qes_coef_if #(parameter int W = qes_pkg::COEF_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// Root result channel.
interface qes_root_if #(parameter int W = qes_pkg::COEF_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic [1:0]          root_count;
  logic signed [W-1:0] root_first;
  logic signed [W-1:0] root_second;
  logic                overflow;
  modport source (output valid, root_count, root_first, root_second, overflow,
                  input ready);
  modport sink   (input valid, root_count, root_first, root_second, overflow,
                  output ready);
endinterface

// Configuration write channel for the zero tolerance.
interface qes_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qes_pkg::TOL_WIDTH-1:0]    zero_tolerance;
  modport source (output valid, zero_tolerance, input ready);
  modport sink   (input valid, zero_tolerance, output ready);
endinterface

// ----- rtl/qes_front.sv -----
// ----------------------------------------------------------------------------
// qes_front
// Four-stage front end: coefficient magnitudes, products, discriminant and
// classification of the equation.
// ----------------------------------------------------------------------------
module qes_front #(
  parameter int W = qes_pkg::COEF_WIDTH_DEF,
  parameter int F = qes_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic [qes_pkg::TOL_WIDTH-1:0]    tol,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              a,
  input  logic signed [W-1:0]              b,
  input  logic signed [W-1:0]              c,
  output logic                             out_valid,
  output logic [2*W+1:0]                   rad,
  output qes_pkg::ctl_t                    ctl,
  output logic [W:0]                       divisor,
  output logic signed [W:0]                negb,
  output logic [W-1:0]                     nmag_lin
);
  import qes_pkg::*;

  localparam int DW = 2*W+1;
  localparam int RW = 2*W+2;
  localparam int TW = TOL_WIDTH + F;
  localparam int XW = (DW > TW) ? DW : TW;

  // Stage A: sign and magnitude of each coefficient, zero tests.
  logic [W-1:0] ma_n, mb_n, mc_n;
  logic         a_v, sa, sb, sc, za, zb, zc;
  logic [W-1:0] ma, mb, mc;

  assign ma_n = a[W-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
  assign mb_n = b[W-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);
  assign mc_n = c[W-1] ? (~$unsigned(c) + 1'b1) : $unsigned(c);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= a[W-1];
      sb <= b[W-1];
      sc <= c[W-1];
      ma <= ma_n;
      mb <= mb_n;
      mc <= mc_n;
      za <= (ma_n <= W'(tol));
      zb <= (mb_n <= W'(tol));
      zc <= (mc_n <= W'(tol));
    end
  end

  // Stage B: the two products b*b and a*c.
  logic           b_v, b_sa, b_sb, b_sc, b_za, b_zb, b_zc;
  logic [W-1:0]   b_ma, b_mb, b_mc;
  logic [2*W-1:0] bb, ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb   <= mb * mb;
      ac   <= ma * mc;
      b_sa <= sa;
      b_sb <= sb;
      b_sc <= sc;
      b_za <= za;
      b_zb <= zb;
      b_zc <= zc;
      b_ma <= ma;
      b_mb <= mb;
      b_mc <= mc;
    end
  end

  // Stage C: discriminant in sign and magnitude.
  logic [RW-1:0] bb_x, ac4, d_sum;
  logic [RW:0]   d_diff;
  logic [DW-1:0] dmag_n, dmag;
  logic          dneg_n, dneg;
  logic          c_v, c_sa, c_sb, c_sc, c_za, c_zb, c_zc;
  logic [W-1:0]  c_ma, c_mb, c_mc;

  assign bb_x   = {2'b00, bb};
  assign ac4    = {ac, 2'b00};
  assign d_sum  = bb_x + ac4;
  assign d_diff = {1'b0, bb_x} - {1'b0, ac4};

  always_comb begin
    if ((b_sa != b_sc) && (b_mc != '0)) begin
      dmag_n = d_sum[DW-1:0];
      dneg_n = 1'b0;
    end else if (!d_diff[RW]) begin
      dmag_n = d_diff[DW-1:0];
      dneg_n = 1'b0;
    end else begin
      dmag_n = DW'(ac4 - bb_x);
      dneg_n = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag <= dmag_n;
      dneg <= dneg_n;
      c_sa <= b_sa;
      c_sb <= b_sb;
      c_sc <= b_sc;
      c_za <= b_za;
      c_zb <= b_zb;
      c_zc <= b_zc;
      c_ma <= b_ma;
      c_mb <= b_mb;
      c_mc <= b_mc;
    end
  end

  // Stage D: classify the equation and set up square root and divisions.
  logic [XW-1:0] thr;
  logic          dz;
  ctl_t          ctl_n;

  assign thr = XW'(tol) << F;
  assign dz  = (XW'(dmag) <= thr);

  always_comb begin
    ctl_n.lin      = c_za;
    ctl_n.dsign    = c_za ? c_sb : c_sa;
    ctl_n.nneg_lin = !c_sc && (c_mc != '0);
    if (c_za) begin
      if (c_zb) begin
        ctl_n.count = c_zc ? CNT_ALL : CNT_NONE;
      end else begin
        ctl_n.count = CNT_ONE;
      end
    end else if (dz) begin
      ctl_n.count = CNT_ONE;
    end else if (!dneg) begin
      ctl_n.count = CNT_TWO;
    end else begin
      ctl_n.count = CNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl      <= ctl_n;
      rad      <= (!c_za && (ctl_n.count == CNT_TWO)) ? {1'b0, dmag} : '0;
      divisor  <= c_za ? {1'b0, c_mb} : {c_ma, 1'b0};
      negb     <= c_sb ? $signed({1'b0, c_mb}) : $signed(-{1'b0, c_mb});
      nmag_lin <= c_mc;
    end
  end

endmodule

// ----- rtl/qes_sqrt.sv -----
// ----------------------------------------------------------------------------
// qes_sqrt
// Pipelined floor square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module qes_sqrt #(
  parameter int RW     = 2*qes_pkg::COEF_WIDTH_DEF + 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [RW/2-1:0]   root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int SW  = RW / 2;
  localparam int RMW = SW + 2;

  logic [RW-1:0]     rad_q  [SW];
  logic [RMW-1:0]    rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic [SIDE_W-1:0] side_q [SW];
  logic              vld_q  [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0]     rad_i;
    logic [RMW-1:0]    rem_i, rem_t, trial;
    logic [SW-1:0]     root_i;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i, ge;

    // Stage input: the port for the first stage, the previous stage otherwise.
    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = side_in;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rad_i  = rad_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign side_i = side_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem_t = {rem_i[RMW-3:0], rad_i[RW-1:RW-2]};
    assign trial = {root_i, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_i << 2;
        rem_q[k]  <= ge ? (rem_t - trial) : rem_t;
        root_q[k] <= {root_i[SW-2:0], ge};
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[SW-1];
  assign root      = root_q[SW-1];
  assign side_out  = side_q[SW-1];

endmodule

// ----- rtl/qes_div.sv -----
// ----------------------------------------------------------------------------
// qes_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module qes_div #(
  parameter int NW     = 50,
  parameter int DVW    = 33,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     num,
  input  logic [DVW-1:0]    den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NW-1:0]     quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [NW-1:0]     n_q    [NW];
  logic [DVW-1:0]    r_q    [NW];
  logic [DVW-1:0]    d_q    [NW];
  logic [NW-1:0]     q_q    [NW];
  logic [SIDE_W-1:0] side_q [NW];
  logic              vld_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0]     n_i, q_i;
    logic [DVW-1:0]    r_i, d_i;
    logic [DVW:0]      r_t;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i, ge;

    // Stage input: the port for the first stage, the previous stage otherwise.
    if (k == 0) begin : g_first
      assign n_i    = num;
      assign r_i    = '0;
      assign d_i    = den;
      assign q_i    = '0;
      assign side_i = side_in;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign n_i    = n_q[k-1];
      assign r_i    = r_q[k-1];
      assign d_i    = d_q[k-1];
      assign q_i    = q_q[k-1];
      assign side_i = side_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    // Shift in the next numerator bit and subtract the divisor if it fits.
    assign r_t = {r_i, n_i[NW-1]};
    assign ge  = (r_t >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[k]    <= n_i << 1;
        r_q[k]    <= ge ? DVW'(r_t - {1'b0, d_i}) : r_t[DVW-1:0];
        d_q[k]    <= d_i;
        q_q[k]    <= {q_i[NW-2:0], ge};
        side_q[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_q[NW-1];
  assign quo       = q_q[NW-1];
  assign side_out  = side_q[NW-1];

endmodule

// ----- rtl/quadratic_equation_solver_top.sv -----
// ----------------------------------------------------------------------------
// quadratic_equation_solver_top
// Fixed-point solver of a*x^2 + b*x + c = 0 with saturated roots.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  coef     in         coef_a, coef_b, coef_c (signed fixed point)
//  root     out        root_count, root_first, root_second, overflow
//  cfg      in         zero_tolerance (write only, always ready)
//
//  One request enters per cycle while root is not stalled; the depth of the
//  pipeline is set by the bit-per-stage square root and dividers.
//  Synchronous reset clears the valid bits and sets the tolerance to 1.
//  A stall on root holds the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_top #(
  parameter int COEF_WIDTH = qes_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qes_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  qes_coef_if.sink coef,
  qes_root_if.source root,
  qes_cfg_if.sink  cfg
);
  import qes_pkg::*;

  localparam int W      = COEF_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int RW     = 2*W + 2;
  localparam int SW     = RW / 2;
  localparam int NMW    = W + 2;
  localparam int NW     = NMW + F;
  localparam int DVW    = W + 1;
  localparam int SIDE_W = CTL_W + DVW + (W + 1) + W;

  // Pipeline advances whenever the output register is free or being taken.
  logic adv;
  assign adv        = !root.valid || root.ready;
  assign coef.ready = adv;

  // Zero tolerance register.
  logic [TOL_WIDTH-1:0] tol;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg.valid) begin
      tol <= cfg.zero_tolerance;
    end
  end

  // Front end.
  logic              f_v;
  logic [RW-1:0]     f_rad;
  ctl_t              f_ctl;
  logic [DVW-1:0]    f_div;
  logic signed [W:0] f_negb;
  logic [W-1:0]      f_nlin;

  qes_front #(.W(W), .F(F)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .tol       (tol),
    .in_valid  (coef.valid),
    .a         (coef.coef_a),
    .b         (coef.coef_b),
    .c         (coef.coef_c),
    .out_valid (f_v),
    .rad       (f_rad),
    .ctl       (f_ctl),
    .divisor   (f_div),
    .negb      (f_negb),
    .nmag_lin  (f_nlin)
  );

  // Square root of the discriminant.
  logic              s_v;
  logic [SW-1:0]     s_root;
  logic [SIDE_W-1:0] s_side;
  ctl_t              s_ctl;
  logic [DVW-1:0]    s_div;
  logic [W:0]        s_negb;
  logic [W-1:0]      s_nlin;

  qes_sqrt #(.RW(RW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (f_v),
    .rad       (f_rad),
    .side_in   ({f_ctl, f_div, f_negb, f_nlin}),
    .out_valid (s_v),
    .root      (s_root),
    .side_out  (s_side)
  );

  assign {s_ctl, s_div, s_negb, s_nlin} = s_side;

  // Numerators -b + s and -b - s, or -c in the linear case.
  logic [W+2:0]   v1, v2, m1, m2;
  logic           e_v, e_n1, e_n2;
  logic [NMW-1:0] e_m1, e_m2;
  logic [DVW-1:0] e_div;
  ctl_t           e_ctl;

  assign v1 = {{2{s_negb[W]}}, s_negb} + {2'b00, s_root};
  assign v2 = {{2{s_negb[W]}}, s_negb} - {2'b00, s_root};
  assign m1 = v1[W+2] ? (~v1 + 1'b1) : v1;
  assign m2 = v2[W+2] ? (~v2 + 1'b1) : v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_n1  <= s_ctl.lin ? s_ctl.nneg_lin : v1[W+2];
      e_m1  <= s_ctl.lin ? {2'b00, s_nlin} : m1[NMW-1:0];
      e_n2  <= v2[W+2];
      e_m2  <= m2[NMW-1:0];
      e_div <= s_div;
      e_ctl <= s_ctl;
    end
  end

  // Two parallel dividers for the two roots.
  logic                 d1_v, d2_v, d_n2;
  logic [NW-1:0]        q1, q2;
  logic [CTL_W:0]       d1_side;
  ctl_t                 d_ctl;
  logic                 d_n1;

  qes_div #(.NW(NW), .DVW(DVW), .SIDE_W(CTL_W + 1)) u_div1 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_v),
    .num       ({e_m1, F'(0)}),
    .den       (e_div),
    .side_in   ({e_ctl, e_n1}),
    .out_valid (d1_v),
    .quo       (q1),
    .side_out  (d1_side)
  );

  qes_div #(.NW(NW), .DVW(DVW), .SIDE_W(1)) u_div2 (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (e_v),
    .num       ({e_m2, F'(0)}),
    .den       (e_div),
    .side_in   (e_n2),
    .out_valid (d2_v),
    .quo       (q2),
    .side_out  (d_n2)
  );

  assign {d_ctl, d_n1} = d1_side;

  // Signed, saturated root from a quotient magnitude; overflow in the top bit.
  function automatic logic [W:0] sat_root(input logic [NW-1:0] q, input logic nneg,
                                          input logic dsign);
    logic          neg;
    logic [NW-1:0] lim;
    logic [NW-1:0] mag;
    logic          ovf;
    neg = (nneg != dsign) && (q != '0);
    lim = (NW'(1) << (W-1)) - (neg ? NW'(0) : NW'(1));
    ovf = (q > lim);
    mag = ovf ? lim : q;
    return {ovf, neg ? (~mag[W-1:0] + 1'b1) : mag[W-1:0]};
  endfunction

  logic [W:0] r1, r2;
  assign r1 = sat_root(q1, d_n1, d_ctl.dsign);
  assign r2 = sat_root(q2, d_n2, d_ctl.dsign);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      root.valid <= 1'b0;
    end else if (adv) begin
      root.valid <= d1_v && d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      root.root_count <= d_ctl.count;
      case (d_ctl.count)
        CNT_ONE: begin
          root.root_first  <= r1[W-1:0];
          root.root_second <= '0;
          root.overflow    <= r1[W];
        end
        CNT_TWO: begin
          root.root_first  <= r1[W-1:0];
          root.root_second <= r2[W-1:0];
          root.overflow    <= r1[W] | r2[W];
        end
        default: begin
          root.root_first  <= '0;
          root.root_second <= '0;
          root.overflow    <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the quadratic equation solver. A local model of the
// solver predicts the root result of each accepted request without a typed
// result; the results that come out are compared field by field in order. A
// directed table is followed by random phases under several zero tolerances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import qes_pkg::*;

  localparam int W          = 32;
  localparam int FB         = 16;
  localparam int LATENCY    = 2 * W + FB + 9;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 1800;

  typedef struct {
    logic [1:0]   cnt;
    logic [W-1:0] r1;
    logic [W-1:0] r2;
    logic         ovf;
  } roots_t;

  typedef struct {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] c;
    bit           typed;
    roots_t       res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qes_coef_if #(W) coef_ch ();
  qes_root_if #(W) root_ch ();
  qes_cfg_if       cfg_ch ();

  quadratic_equation_solver_top #(.COEF_WIDTH(W), .FRAC_BITS(FB)) dut (
    .clk  (clk),
    .rst  (rst),
    .coef (coef_ch),
    .root (root_ch),
    .cfg  (cfg_ch)
  );

  always #5 clk = ~clk;

  roots_t          pending_roots[$];
  logic [7:0]      tol_shadow = TOL_RESET;
  int              errors = 0;
  int              idle_cycles = 0;
  bit              rx_busy = 1'b1;

  // Split a two's complement field into sign and magnitude.
  function automatic void to_sign_mag(input logic [W-1:0] v, output bit neg,
                                      output logic [63:0] mag);
    logic [W-1:0] m;
    neg = v[W-1];
    m   = neg ? (~v + 1'b1) : v;
    mag = {32'd0, m};
  endfunction

  // (num << FB) / den, truncated toward zero, saturated to the field range.
  function automatic logic [W-1:0] sat_quot(input bit nneg, input logic [63:0] nmag,
                                            input bit dneg, input logic [63:0] dmag,
                                            inout bit ovf);
    logic [127:0] q;
    logic [63:0]  lim;
    logic [63:0]  mag;
    bit           neg;
    q   = ({64'd0, nmag} << FB) / {64'd0, dmag};
    neg = (nneg != dneg) && (q != 0);
    lim = (64'd1 << (W - 1)) - (neg ? 64'd0 : 64'd1);
    if (q > {64'd0, lim}) begin
      mag = lim;
      ovf = 1'b1;
    end else begin
      mag = q[63:0];
    end
    return neg ? W'(~mag + 1'b1) : W'(mag);
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0] s;
    logic [63:0] t;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      t = s | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= v) s = t;
    end
    return s;
  endfunction

  // Predicted result of one coefficient set under tolerance tol.
  function automatic roots_t solve_roots(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] c, input logic [7:0] tol);
    roots_t       r;
    bit           sa, sb, sc, ovf, dneg, nn;
    logic [63:0]  ma, mb, mc, nm, tl;
    logic [127:0] bb, ac4, thr, dmag;
    longint       negb, s, v;
    r   = '{CNT_NONE, '0, '0, 1'b0};
    ovf = 1'b0;
    tl  = {56'd0, tol};
    to_sign_mag(a, sa, ma);
    to_sign_mag(b, sb, mb);
    to_sign_mag(c, sc, mc);
    if (ma <= tl) begin
      // Linear equation b*x + c = 0.
      if (mb <= tl) begin
        r.cnt = (mc <= tl) ? CNT_ALL : CNT_NONE;
      end else begin
        r.r1  = sat_quot(!sc && mc != 0, mc, sb, mb, ovf);
        r.cnt = CNT_ONE;
      end
    end else begin
      bb   = {64'd0, mb} * {64'd0, mb};
      ac4  = ({64'd0, ma} * {64'd0, mc}) << 2;
      thr  = {64'd0, tl} << FB;
      negb = sb ? longint'(mb) : -longint'(mb);
      if (sa != sc && mc != 0) begin
        dmag = bb + ac4;
        dneg = 1'b0;
      end else if (bb >= ac4) begin
        dmag = bb - ac4;
        dneg = 1'b0;
      end else begin
        dmag = ac4 - bb;
        dneg = 1'b1;
      end
      if (dmag <= thr) begin
        // Double root.
        nn    = negb < 0;
        nm    = nn ? 64'(-negb) : 64'(negb);
        r.r1  = sat_quot(nn, nm, sa, ma << 1, ovf);
        r.cnt = CNT_ONE;
      end else if (!dneg) begin
        s     = longint'(floor_sqrt(dmag));
        v     = negb + s;
        nn    = v < 0;
        nm    = nn ? 64'(-v) : 64'(v);
        r.r1  = sat_quot(nn, nm, sa, ma << 1, ovf);
        v     = negb - s;
        nn    = v < 0;
        nm    = nn ? 64'(-v) : 64'(v);
        r.r2  = sat_quot(nn, nm, sa, ma << 1, ovf);
        r.cnt = CNT_TWO;
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Send one coefficient request and queue its expected roots on acceptance.
  task automatic send_coefs(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] c, input roots_t want);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef_ch.valid  <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    do @(posedge clk); while (!coef_ch.ready);
    pending_roots.push_back(want);
  endtask

  task automatic send_predicted(input logic [W-1:0] a, input logic [W-1:0] b,
                                input logic [W-1:0] c);
    send_coefs(a, b, c, solve_roots(a, b, c, tol_shadow));
  endtask

  // Wait for the pipeline to drain, then write the tolerance.
  task automatic write_tolerance(input logic [7:0] v);
    coef_ch.valid <= 1'b0;
    wait (pending_roots.size() == 0);
    repeat (LATENCY) @(posedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.zero_tolerance <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tol_shadow = v;
  endtask

  // One random coefficient set, biased towards the interesting regions.
  task automatic send_random();
    logic [W-1:0] a, b, c;
    int           r1, r2, k;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        // Near-zero a: linear path and the tolerance edge.
        a = W'($urandom_range(0, 600) - 300);
        if ($urandom_range(0, 1)) b = W'($urandom_range(0, 600) - 300);
      end
      3: begin
        a = W'($urandom_range(0, 600) - 300);
        b = W'($urandom_range(0, 600) - 300);
        c = W'($urandom_range(0, 600) - 300);
      end
      4, 5, 6: begin
        // Integer roots r1, r2 with a = k.
        k  = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1);
        r1 = $urandom_range(0, 200) - 100;
        r2 = $urandom_range(0, 200) - 100;
        a  = W'(k <<< FB);
        b  = W'(-k * (r1 + r2) <<< FB);
        c  = W'(k * r1 * r2 <<< FB);
      end
      7: begin
        // Double root, with a little noise on c to probe the D tolerance.
        k  = $urandom_range(1, 20);
        r1 = $urandom_range(0, 100) - 50;
        a  = W'(k <<< FB);
        b  = W'(-2 * k * r1 <<< FB);
        c  = W'((k * r1 * r1 <<< FB) + ($urandom_range(0, 8) - 4));
      end
      default: begin
        a = W'($signed($urandom()) >>> $urandom_range(8, 24));
        b = W'($signed($urandom()) >>> $urandom_range(0, 24));
        c = W'($signed($urandom()) >>> $urandom_range(0, 24));
      end
    endcase
    send_predicted(a, b, c);
  endtask

  // Directed table; typed results only where obvious.
  stim_row_t stim_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, '{CNT_ALL, 0, 0, 0}},
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1, '{CNT_NONE, 0, 0, 0}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1, '{CNT_ALL, 0, 0, 0}},
    '{32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 1, '{CNT_ONE, 32'hFFFE_0000, 0, 0}},
    '{32'h0000_0000, 32'h0000_0002, 32'h7FFF_FFFF, 1, '{CNT_ONE, 32'h8000_0000, 0, 1}},
    '{32'h0000_0000, 32'h0000_0002, 32'h8000_0000, 1, '{CNT_ONE, 32'h7FFF_FFFF, 0, 1}},
    '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 1,
      '{CNT_TWO, 32'h0001_0000, 32'hFFFF_0000, 0}},
    '{32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1, '{CNT_NONE, 0, 0, 0}},
    '{32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 1, '{CNT_ONE, 32'h0001_0000, 0, 0}},
    '{32'h0000_0002, 32'h7FFF_FFFF, 32'h0000_0000, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'hFFFF_FFFE, 32'h0000_0003, 32'h0000_0001, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h0002_0000, 32'h0006_0000, 32'h0004_0000, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'hFFFD_0000, 32'h0001_8000, 32'h0000_4000, 0, '{CNT_NONE, 0, 0, 0}},
    '{32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFF, 0, '{CNT_NONE, 0, 0, 0}}
  };

  // Result side: random stalls, in-order comparison.
  initial begin
    int     gap;
    int     n;
    roots_t want;
    root_ch.ready <= 1'b0;
    wait (!rst);
    n = 0;
    forever begin
      if (n % 64 == 0) rx_busy = ($urandom_range(0, 3) != 0);
      n++;
      gap = rx_busy ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        root_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      root_ch.ready <= 1'b1;
      do @(posedge clk); while (!(root_ch.valid && root_ch.ready));
      if (pending_roots.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_roots.pop_front();
        if (root_ch.root_count !== want.cnt)
          report($sformatf("root_count %0d, expected %0d", root_ch.root_count, want.cnt));
        if (root_ch.root_first !== want.r1)
          report($sformatf("root_first %h, expected %h", root_ch.root_first, want.r1));
        if (root_ch.root_second !== want.r2)
          report($sformatf("root_second %h, expected %h", root_ch.root_second, want.r2));
        if (root_ch.overflow !== want.ovf)
          report($sformatf("overflow %b, expected %b", root_ch.overflow, want.ovf));
      end
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk) begin
    if ((coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    logic [7:0] tol_list[5];
    tol_list = '{8'd0, 8'd255, 8'd0, 8'd17, 8'd1};
    coef_ch.valid         <= 1'b0;
    coef_ch.coef_a        <= '0;
    coef_ch.coef_b        <= '0;
    coef_ch.coef_c        <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.zero_tolerance <= '0;
    rst                   <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset tolerance.
    foreach (stim_rows[i]) begin
      if (stim_rows[i].typed)
        send_coefs(stim_rows[i].a, stim_rows[i].b, stim_rows[i].c, stim_rows[i].res);
      else
        send_predicted(stim_rows[i].a, stim_rows[i].b, stim_rows[i].c);
    end

    // Random phases, each under its own tolerance.
    for (int p = 0; p < 6; p++) begin
      write_tolerance(p < 5 ? tol_list[p] : 8'($urandom_range(2, 254)));
      for (int i = 0; i < N_RANDOM / 6; i++) send_random();
    end
    coef_ch.valid <= 1'b0;

    wait (pending_roots.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
